FILE: rtl/ksfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_pkg
// Shared types and constants of the fixed-partition multi-stack block.
// ----------------------------------------------------------------------------
package ksfp_pkg;

    // Fixed field widths of the ports.
    localparam int SC_W       = 4;   // stack_count register
    localparam int TE_W       = 11;  // total_entries register
    localparam int SID_W      = 3;   // stack number
    localparam int DATA_W     = 32;  // stored value
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ENTRIES = 2'd1;

    // Register values after reset.
    localparam logic [SC_W-1:0] RESET_STACK_COUNT   = 4'd8;
    localparam logic [TE_W-1:0] RESET_TOTAL_ENTRIES = 11'd1024;

    // Value returned by a pop from an empty stack.
    localparam logic [DATA_W-1:0] DATA_EMPTY = 32'hFFFF_FFFF;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input action codes.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    // Memory operation that the back part carries out.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t status;
    } cmd_ctl_t;

endpackage

FILE: rtl/ksfp_slice_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_slice_div
// Restoring divider that computes the slice size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ksfp_slice_div
    import ksfp_pkg::*;
#(
    parameter int FW        = 11,
    parameter int RESET_QUO = 128
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [FW-1:0]   dividend,
    input  logic [SC_W-1:0] divisor,
    output logic            busy,
    output logic [FW-1:0]   quotient
);

    localparam int CNT_W = $clog2(FW + 1);

    logic            busy_reg;
    logic [FW-1:0]   quo_reg;
    logic [FW-1:0]   dvd_reg;
    logic [SC_W-1:0] dvs_reg;
    logic [SC_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [SC_W:0]   trial;
    logic            ge;
    logic [SC_W-1:0] rem_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial    = {rem_reg, dvd_reg[FW-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? SC_W'(trial - {1'b0, dvs_reg}) : trial[SC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            quo_reg  <= FW'(RESET_QUO);
            cnt_reg  <= '0;
        end else if (start) begin
            // A zero divisor gives a zero slice without iterating.
            quo_reg <= '0;
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= CNT_W'(FW);
            busy_reg <= (divisor != '0);
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[FW-2:0], ge};
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[FW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/ksfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_front
// Accepts transactions, holds configuration and fill counts, and classifies
// each push or pop into a memory command for the back part.
// ----------------------------------------------------------------------------
module ksfp_front
    import ksfp_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_STACKS  = 8,
    parameter int FW          = 11,
    parameter int AW          = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [SID_W-1:0]      s_stack_id,
    input  logic [DATA_W-1:0]     s_value,
    // Slice divider
    output logic                  div_start,
    output logic [FW-1:0]         div_dividend,
    output logic [SC_W-1:0]       div_divisor,
    input  logic                  div_busy,
    input  logic [FW-1:0]         slice_size,
    // Command to the queue
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_ctl_t              cmd_ctl,
    output logic [AW-1:0]         cmd_addr,
    output logic [DATA_W-1:0]     cmd_value
);

    localparam int SIDX_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int PROD_W = FW + SID_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [6:0]  MAX_STACKS_7 = 7'(MAX_STACKS);
    localparam logic [31:0] MAX_ENTRIES_32 = 32'(MAX_ENTRIES);

    logic [SC_W-1:0] stack_count_reg;
    logic [TE_W-1:0] total_entries_reg;
    logic [FW-1:0]   fill_reg [MAX_STACKS];

    logic [SC_W-1:0]   stack_count_next;
    logic [TE_W-1:0]   total_entries_next;
    logic              cfg_hit;
    logic [SC_W-1:0]   live_stacks;
    logic [SIDX_W-1:0] sid_idx;
    logic [FW-1:0]     cur_fill;
    logic [FW-1:0]     fill_dec;
    logic              accept;
    logic              bad_stack;
    logic [PROD_W-1:0] base_addr;
    logic [SUM_W-1:0]  full_addr;

    // Configuration decode; every write of a listed register repartitions.
    always_comb begin
        cfg_hit = cfg_we && ((cfg_index == CFG_STACK_COUNT) ||
                             (cfg_index == CFG_TOTAL_ENTRIES));
        stack_count_next   = stack_count_reg;
        total_entries_next = total_entries_reg;
        if (cfg_we && (cfg_index == CFG_STACK_COUNT)) begin
            stack_count_next = cfg_data[SC_W-1:0];
        end
        if (cfg_we && (cfg_index == CFG_TOTAL_ENTRIES)) begin
            total_entries_next = cfg_data[TE_W-1:0];
        end
    end

    // Saturated operands of the slice division.
    always_comb begin
        div_start = cfg_hit;
        if (7'(stack_count_next) > MAX_STACKS_7) begin
            div_divisor = SC_W'(MAX_STACKS);
        end else begin
            div_divisor = stack_count_next;
        end
        if (32'(total_entries_next) > MAX_ENTRIES_32) begin
            div_dividend = FW'(MAX_ENTRIES);
        end else begin
            div_dividend = FW'(total_entries_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_count_reg   <= RESET_STACK_COUNT;
            total_entries_reg <= RESET_TOTAL_ENTRIES;
        end else begin
            stack_count_reg   <= stack_count_next;
            total_entries_reg <= total_entries_next;
        end
    end

    // Items are held off during a configuration write, while the slice
    // size is being recomputed and while the command queue is full.
    assign s_ready   = !cfg_we && !div_busy && cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = accept;
    assign cmd_value = s_value;

    // Classification of the transaction.
    always_comb begin
        if (7'(stack_count_reg) > MAX_STACKS_7) begin
            live_stacks = SC_W'(MAX_STACKS);
        end else begin
            live_stacks = stack_count_reg;
        end
        sid_idx   = SIDX_W'(s_stack_id);
        cur_fill  = fill_reg[sid_idx];
        fill_dec  = cur_fill - 1'b1;
        bad_stack = ({1'b0, s_stack_id} >= live_stacks) ||
                    (7'(s_stack_id) >= MAX_STACKS_7);
        base_addr = PROD_W'(s_stack_id) * PROD_W'(slice_size);
        if (s_action == ACT_PUSH) begin
            full_addr = SUM_W'(base_addr) + SUM_W'(cur_fill);
        end else begin
            full_addr = SUM_W'(base_addr) + SUM_W'(fill_dec);
        end
        cmd_addr = AW'(full_addr);

        priority if (bad_stack) begin
            cmd_ctl = '{op: OP_NONE, status: ST_BAD};
        end else if (s_action == ACT_PUSH) begin
            if (cur_fill >= slice_size) begin
                cmd_ctl = '{op: OP_NONE, status: ST_FULL};
            end else begin
                cmd_ctl = '{op: OP_WRITE, status: ST_OK};
            end
        end else begin
            if (cur_fill == '0) begin
                cmd_ctl = '{op: OP_NONE, status: ST_EMPTY};
            end else begin
                cmd_ctl = '{op: OP_READ, status: ST_OK};
            end
        end
    end

    // Fill counters: cleared by reset and by repartitioning.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            for (int i = 0; i < MAX_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (accept) begin
            if (cmd_ctl.op == OP_WRITE) begin
                fill_reg[sid_idx] <= cur_fill + 1'b1;
            end else if (cmd_ctl.op == OP_READ) begin
                fill_reg[sid_idx] <= fill_dec;
            end
        end
    end

`ifndef SYNTHESIS
    // A successful push raises exactly that stack's fill by one.
    a_push_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd_ctl.op == OP_WRITE)) |=>
        (fill_reg[$past(sid_idx)] == $past(cur_fill) + 1'b1))
        else $error("push did not advance the fill count");

    // Once the slice is settled, no live stack holds more than a slice.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !div_busy && !bad_stack) |-> (cur_fill <= slice_size))
        else $error("fill count beyond slice size");

    // A memory read is only issued for a nonempty stack.
    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd_ctl.op == OP_READ)) |-> (cur_fill != '0))
        else $error("read issued for an empty stack");
`endif

endmodule

FILE: rtl/ksfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module ksfp_queue
    import ksfp_pkg::*;
#(
    parameter int WIDTH = 46
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    logic do_push;
    logic do_pop;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/ksfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksfp_back
// Carries out memory commands on the shared stack memory and holds the
// result transaction in an output register.
// ----------------------------------------------------------------------------
module ksfp_back
    import ksfp_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int AW          = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  cmd_ctl_t           q_ctl,
    input  logic [AW-1:0]      q_addr,
    input  logic [DATA_W-1:0]  q_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DATA_W-1:0]  m_data_out,
    output logic [1:0]         m_status
);

    logic [DATA_W-1:0] mem [MAX_ENTRIES];

    logic              m_valid_reg;
    status_t           status_reg;
    logic              is_read_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              take;

    // A command moves on when the output slot is empty or being emptied.
    assign q_ready = !m_valid_reg || m_ready;
    assign take    = q_valid && q_ready;

    // Shared stack memory: at most one access per command.
    always_ff @(posedge aclk) begin
        if (take && (q_ctl.op == OP_WRITE)) begin
            mem[q_addr] <= q_value;
        end
        if (take && (q_ctl.op == OP_READ)) begin
            rd_data_reg <= mem[q_addr];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg  <= q_ctl.status;
            is_read_reg <= (q_ctl.op == OP_READ);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_data_out = is_read_reg ? rd_data_reg :
                        ((status_reg == ST_EMPTY) ? DATA_EMPTY : '0);

`ifndef SYNTHESIS
    // A read command turns into a valid result that carries memory data.
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && (q_ctl.op == OP_READ)) |=> (m_valid_reg && is_read_reg))
        else $error("read command lost on its way to the output");

    // Memory data is only ever returned with status ok.
    a_read_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && is_read_reg) |-> (status_reg == ST_OK))
        else $error("memory data returned with an error status");
`endif

endmodule

FILE: rtl/k_stacks_fixed_partition_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_stacks_fixed_partition_top
// Several stacks in one shared memory, each owning an equal fixed slice.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (s_valid/s_ready) carry a push or pop, a stack number
//   and a value. Each one gives exactly one result transaction
//   (m_valid/m_ready) with the popped data and a status code, in order.
//   After an input is accepted, the front classifies it into the command
//   queue, and the back does the memory access, if any, and loads the output
//   register. One transaction per cycle is sustained while the receiver takes
//   results and no configuration write or slice recompute holds s_ready low.
//   Configuration writes (cfg_we, cfg_index, cfg_data) set the stack count
//   or the total entry count; each one empties every stack and restarts the
//   slice-size divider, which holds s_ready low while it runs. The user must
//   make writes only while no transaction is in flight; the block does not enforce this.
//   After reset every stack is empty and the slice size is already set; no
//   memory clearing pass runs. When the receiver stalls, the output register
//   holds its result and the four-entry queue absorbs further transactions
//   before s_ready falls.
// ----------------------------------------------------------------------------
module k_stacks_fixed_partition_top
    import ksfp_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_STACKS  = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_action,
    input  logic [SID_W-1:0]         s_stack_id,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_data_out,
    output logic [1:0]               m_status
);

    localparam int FW_RAW = $clog2(MAX_ENTRIES + 1);
    localparam int FW     = (FW_RAW < TE_W) ? FW_RAW : TE_W;
    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int RESET_T = (MAX_ENTRIES < 1024) ? MAX_ENTRIES : 1024;
    localparam int RESET_N = (MAX_STACKS < 8) ? MAX_STACKS : 8;
    localparam int RESET_SLICE = RESET_T / RESET_N;
    localparam int CMD_W = $bits(cmd_ctl_t) + AW + DATA_W;

    logic            div_start;
    logic [FW-1:0]   div_dividend;
    logic [SC_W-1:0] div_divisor;
    logic            div_busy;
    logic [FW-1:0]   slice_size;

    logic              cmd_valid;
    logic              cmd_ready;
    cmd_ctl_t          cmd_ctl;
    logic [AW-1:0]     cmd_addr;
    logic [DATA_W-1:0] cmd_value;

    logic              q_valid;
    logic              q_ready;
    logic [CMD_W-1:0]  q_data;
    cmd_ctl_t          q_ctl;
    logic [AW-1:0]     q_addr;
    logic [DATA_W-1:0] q_value;
    logic [DATA_W-1:0] back_data;

    ksfp_slice_div #(
        .FW        (FW),
        .RESET_QUO (RESET_SLICE)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (slice_size)
    );

    ksfp_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_STACKS  (MAX_STACKS),
        .FW          (FW),
        .AW          (AW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_stack_id   (s_stack_id),
        .s_value      (s_value),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .slice_size   (slice_size),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd_ctl      (cmd_ctl),
        .cmd_addr     (cmd_addr),
        .cmd_value    (cmd_value)
    );

    ksfp_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd_valid),
        .in_ready  (cmd_ready),
        .in_data   ({cmd_ctl, cmd_addr, cmd_value}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // Unpack the queued command.
    assign {q_ctl, q_addr, q_value} = q_data;

    ksfp_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_ctl      (q_ctl),
        .q_addr     (q_addr),
        .q_value    (q_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (back_data),
        .m_status   (m_status)
    );

    assign m_data_out = back_data;

endmodule
